[sv/fft_polynomial_multiply_top_assert.svh]
// Assertion macros for the polynomial multiplier controller.
// Each macro expects signals named clk and rst in the using module.
`ifndef FFT_POLYNOMIAL_MULTIPLY_TOP_ASSERT_SVH
`define FFT_POLYNOMIAL_MULTIPLY_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FPM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpm assertion failed");

// Next-cycle implication, disabled during reset.
`define FPM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpm assertion failed");

`endif

[sv/fpm_pkg.sv]
// Shared types and constants for the polynomial multiplier.
// No dependencies.
package fpm_pkg;

  localparam int DEF_MAX_TERMS = 1024;
  localparam int DEF_COEF_BITS = 8;
  localparam int PCOEF_W       = 26;
  localparam int PDEG_W        = 11;
  localparam int RIDX_W        = 11;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ISSUE,
    ST_DRAIN,
    ST_WRITE,
    ST_READ
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_en;
    logic prod_start;
    logic read_en;
    logic setup;
    logic issue;
    logic write;
    logic rsp_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic issue_last;
    logic pipe_busy;
    logic last_k;
  } stat_t;

endpackage

[sv/fpm_datapath.sv]
// Datapath: coefficient and product memories, index counters and the
// multiply-accumulate pipeline. Depends on fpm_pkg.
module fpm_datapath
  import fpm_pkg::*;
#(
  parameter int MAX_TERMS = DEF_MAX_TERMS,
  parameter int COEF_BITS = DEF_COEF_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic [7:0]          coef_a,
  input  logic [7:0]          coef_b,
  input  logic [RIDX_W-1:0]   read_index,
  output stat_t               stat,
  output logic [PCOEF_W-1:0]  product_coef,
  output logic [PDEG_W-1:0]   product_degree,
  output logic                in_range
);

  localparam int AW  = $clog2(MAX_TERMS);
  localparam int PAW = AW + 1;
  localparam int PW  = 2 * COEF_BITS + AW + 1;
  localparam int XW  = (COEF_BITS > 8) ? COEF_BITS : 8;
  localparam int CW  = (RIDX_W > PAW) ? RIDX_W : PAW;

  logic [COEF_BITS-1:0] a_mem [MAX_TERMS];
  logic [COEF_BITS-1:0] b_mem [MAX_TERMS];
  logic [PW-1:0]        p_mem [2 * MAX_TERMS];

  logic [AW:0]          count;
  logic [AW-1:0]        da, db, da_new, db_new, pa, pb;
  logic [PAW-1:0]       deg, k;
  logic [AW-1:0]        i, lo, hi;
  logic                 zero_prod;
  logic [COEF_BITS-1:0] ra, rb, ca, cb;
  logic [2*COEF_BITS-1:0] prod;
  logic [PW-1:0]        acc, p_rd;
  logic                 v1, v2, in_r;
  logic                 load_ok;
  logic [XW-1:0]        ax, bx;
  logic [CW-1:0]        rx;
  logic [PAW-1:0]       k_lo;

  // Coefficient bits above the configured width are dropped.
  assign ax = XW'(coef_a);
  assign bx = XW'(coef_b);
  assign ca = ax[COEF_BITS-1:0];
  assign cb = bx[COEF_BITS-1:0];
  assign load_ok = cmd.load_en && (count < (AW+1)'(MAX_TERMS));
  assign da_new = (load_ok && ca != '0) ? count[AW-1:0] : da;
  assign db_new = (load_ok && cb != '0) ? count[AW-1:0] : db;
  assign rx = CW'(read_index);

  // Summation bounds for the current output index.
  assign k_lo = k - PAW'(pb);
  assign lo = (k > PAW'(pb)) ? k_lo[AW-1:0] : '0;
  assign hi = (k < PAW'(pa)) ? k[AW-1:0] : pa;

  assign stat.issue_last = (i == hi);
  assign stat.pipe_busy  = v1 | v2;
  assign stat.last_k     = (k == deg);

  // Load bookkeeping and product set-up.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      da <= '0;
      db <= '0;
      deg <= '0;
    end else if (cmd.prod_start) begin
      count <= '0;
      da <= '0;
      db <= '0;
      deg <= PAW'(da_new) + PAW'(db_new);
    end else if (load_ok) begin
      count <= count + 1'b1;
      da <= da_new;
      db <= db_new;
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  // Coefficient memories with registered reads.
  always_ff @(posedge clk) begin
    if (load_ok) begin
      a_mem[count[AW-1:0]] <= ca;
      b_mem[count[AW-1:0]] <= cb;
    end
    ra <= a_mem[i];
    rb <= b_mem[k_lo[AW-1:0] + (AW)'(pb) - i];
  end

  // Product memory: write back accumulator, registered read port.
  always_ff @(posedge clk) begin
    if (cmd.write) p_mem[k] <= acc;
    p_rd <= p_mem[rx[PAW-1:0]];
  end

  // Sequencing registers and the multiply-accumulate stages.
  // The result beat is registered whole, so a product started in the
  // same cycle cannot alter the degree shown with it.
  always_ff @(posedge clk) begin
    if (cmd.prod_start) begin
      pa <= da_new;
      pb <= db_new;
      k <= '0;
      zero_prod <= (count == '0) && !load_ok;
    end
    if (cmd.setup) begin
      i <= lo;
      acc <= '0;
    end else if (v2) begin
      acc <= acc + PW'(prod);
    end
    if (cmd.issue) i <= i + 1'b1;
    if (cmd.write) k <= k + 1'b1;
    prod <= zero_prod ? '0 : ra * rb;
    if (cmd.read_en) in_r <= (rx <= CW'(deg));
    if (cmd.rsp_load) product_coef <= in_r ? PCOEF_W'(p_rd) : '0;
    if (cmd.rsp_load) in_range <= in_r;
    if (cmd.rsp_load) product_degree <= PDEG_W'(deg);
  end

endmodule

[sv/fpm_ctrl.sv]
// Controller: sequences loads, the product computation and reads.
// Depends on fpm_pkg and the assertion macro header.
`include "fft_polynomial_multiply_top_assert.svh"
module fpm_ctrl
  import fpm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  kind,
  input  logic  last_term,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  result_valid
);

  state_t state, state_next;

  // State and result strobe registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= (state == ST_READ);
    end
  end

  assign busy = (state != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (kind == KIND_READ) begin
            cmd.read_en = 1'b1;
            state_next = ST_READ;
          end else begin
            cmd.load_en = 1'b1;
            if (last_term) begin
              cmd.prod_start = 1'b1;
              state_next = ST_SETUP;
            end
          end
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (stat.issue_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_next = stat.last_k ? ST_IDLE : ST_SETUP;
      end
      ST_READ: begin
        cmd.rsp_load = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `FPM_ASSERT_NXT(a_read_gives_result, state == ST_READ, result_valid)
  `FPM_ASSERT_NXT(a_single_beat, result_valid, !result_valid)
  `FPM_ASSERT_IMP(a_write_after_drain, state == ST_WRITE, !stat.pipe_busy)

endmodule

[sv/fft_polynomial_multiply_top.sv]
// Polynomial multiplier top level: controller plus datapath.
// Depends on fpm_pkg, fpm_ctrl and fpm_datapath.
//
// Usage: present an item with start high; it is taken at an edge where
// busy is low. kind = 0 loads the next coefficient pair (coef_a, coef_b)
// in ascending index order; last_term = 1 on a load starts the product.
// The product is formed exactly by one shared multiply-accumulate unit
// over a three-stage pipeline: for each output coefficient k the
// controller sets up the bounds, issues each contributing term, drains
// the pipeline and writes the sum back, with busy held high throughout.
// kind = 1 reads a product coefficient: the memory word and range flag
// are registered on acceptance, then loaded into product_coef,
// product_degree and in_range, marked by result_valid for exactly one
// cycle; the receiver cannot stall it. Busy is high while a read runs.
// Reset (rst, synchronous) empties the load sequence and clears the
// degree; product memory contents are undefined until a product is made.
module fft_polynomial_multiply_top
  import fpm_pkg::*;
#(
  parameter int MAX_TERMS = DEF_MAX_TERMS,
  parameter int COEF_BITS = DEF_COEF_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic [7:0]         coef_a,
  input  logic [7:0]         coef_b,
  input  logic               last_term,
  input  logic [RIDX_W-1:0]  read_index,
  output logic               result_valid,
  output logic [PCOEF_W-1:0] product_coef,
  output logic [PDEG_W-1:0]  product_degree,
  output logic               in_range
);

  cmd_t  cmd;
  stat_t stat;

  fpm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .kind         (kind),
    .last_term    (last_term),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  fpm_datapath #(
    .MAX_TERMS (MAX_TERMS),
    .COEF_BITS (COEF_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .coef_a         (coef_a),
    .coef_b         (coef_b),
    .read_index     (read_index),
    .stat           (stat),
    .product_coef   (product_coef),
    .product_degree (product_degree),
    .in_range       (in_range)
  );

endmodule
